/* rtl/core/indexed_min_heap_timer_queue_top_defines.svh */
// assertion macros for the heap timer queue
`ifndef INDEXED_MIN_HEAP_TIMER_QUEUE_TOP_DEFINES_SVH
`define INDEXED_MIN_HEAP_TIMER_QUEUE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define IMH_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("imh assertion failed");
`define IMH_ASSERT_NR(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("imh assertion failed");
`else
`define IMH_ASSERT(label, prop)
`define IMH_ASSERT_NR(label, prop)
`endif
`endif

/* rtl/core/imhtq_pkg.sv */
`default_nettype none
package imhtq_pkg;
	localparam int CAPACITY_DEF  = 64;
	localparam int TIME_BITS_DEF = 32;
	localparam int NUM_IDS       = 64;
	localparam int ID_W          = 6;
	localparam int MAX_RES       = 64;
	localparam int DELAY_W       = 32;
	localparam int NOW_W         = 32;

	localparam logic [1:0] CMD_SET  = 2'd0;
	localparam logic [1:0] CMD_DEL  = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;
endpackage
`default_nettype wire

/* rtl/core/imhtq_req_if.sv */
`default_nettype none
interface imhtq_req_if import imhtq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [ID_W-1:0]    event_id;
	logic [DELAY_W-1:0] delay;
	logic [NOW_W-1:0]   now_ms;

	modport source (output valid, command, event_id, delay, now_ms, input ready);
	modport sink (input valid, command, event_id, delay, now_ms, output ready);
endinterface
`default_nettype wire

/* rtl/core/imhtq_rsp_if.sv */
`default_nettype none
interface imhtq_rsp_if import imhtq_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] out_event;
	logic            expired;
	logic [1:0]      status;
	logic            last;

	modport source (output valid, out_event, expired, status, last, input ready);
	modport sink (input valid, out_event, expired, status, last, output ready);
endinterface
`default_nettype wire

/* rtl/core/indexed_min_heap_timer_queue_top.sv */
// channel | dir | payload                               | handshake
// req     | in  | command, event_id, delay, now_ms      | valid/ready
// rsp     | out | out_event, expired, status, last      | valid/ready
// one item at a time; heap and position map sit in single-port synchronous memories
// set/delete: S_DISP dispatches, then S_UP_RD/S_UP_EV per level moving up or
// S_DN_RD/S_DN_E1/S_DN_E2 per level moving down; tick adds that per popped event
// reset clears only the present bits, the count and the control state; no clearing pass
// a full result register stalls the sequencer until rsp takes it
`default_nettype none
`include "indexed_min_heap_timer_queue_top_defines.svh"
module indexed_min_heap_timer_queue_top import imhtq_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	imhtq_req_if.sink   req,
	imhtq_rsp_if.source rsp
);
	localparam int HW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int NW = $clog2(MAX_RES + 1);
	localparam int SW = (TIME_BITS > 32) ? TIME_BITS : 33;
	localparam int EW = TIME_BITS + ID_W;

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_DISP    = 13'b0000000000010,
		S_UP_RD   = 13'b0000000000100,
		S_UP_EV   = 13'b0000000001000,
		S_DN_RD   = 13'b0000000010000,
		S_DN_E1   = 13'b0000000100000,
		S_DN_E2   = 13'b0000001000000,
		S_LAST_EV = 13'b0000010000000,
		S_TICK_RD = 13'b0000100000000,
		S_TICK_EV = 13'b0001000000000,
		S_POP     = 13'b0010000000000,
		S_EMIT    = 13'b0100000000000,
		S_SPARE   = 13'b1000000000000
	} state_t;

	logic [EW-1:0] heap_mem [CAPACITY];
	logic [HW-1:0] pmap_mem [NUM_IDS];

	state_t state_q, state_d;
	logic [1:0]           cmd_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_BITS-1:0] dl_q, now_q;
	logic [HW-1:0]        h_q, h_d;
	logic [TIME_BITS-1:0] k_q, k_d;
	logic [ID_W-1:0]      kid_q, kid_d;
	logic                 first_q, first_d;
	logic [EW-1:0]        child_q, child_d;
	logic [NW-1:0]        n_q, n_d;
	logic [ID_W-1:0]      pend_q, pend_d, tid_q, tid_d;
	logic                 have_pend_q, have_pend_d;
	logic [CW-1:0]        count_q, count_d;
	logic [NUM_IDS-1:0]   present_q, present_d;
	logic [ID_W-1:0]      e_ev_q, e_ev_d;
	logic                 e_exp_q, e_exp_d, e_last_q, e_last_d;
	logic [1:0]           e_st_q, e_st_d;
	logic                 ov_q;
	logic [ID_W-1:0]      o_ev_q;
	logic                 o_exp_q, o_last_q;
	logic [1:0]           o_st_q;

	logic                 rd_en;
	logic [HW-1:0]        rd_addr;
	logic [EW-1:0]        heap_rd_s1;
	logic [HW-1:0]        pmap_rd_s1;
	logic                 heap_we, pmap_we;
	logic [HW-1:0]        heap_waddr, pmap_wdata;
	logic [EW-1:0]        heap_wdata;
	logic [ID_W-1:0]      pmap_waddr;

	logic                 accept, out_free;
	logic [SW-1:0]        sum_w, now_w;
	logic [HW+1:0]        c1_w, c2_w, cnt_w;
	logic [HW-1:0]        par_idx;
	logic [TIME_BITS-1:0] rd_key, ch_key;
	logic [ID_W-1:0]      rd_id;
	logic [CW-1:0]        cnt_m1;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !ov_q || rsp.ready;
	assign sum_w    = SW'(req.now_ms) + SW'(req.delay);
	assign now_w    = SW'(req.now_ms);
	assign c1_w     = (HW + 2)'({h_q, 1'b1});
	assign c2_w     = c1_w + (HW + 2)'(1);
	assign cnt_w    = (HW + 2)'(count_q);
	assign par_idx  = HW'((h_q - HW'(1)) >> 1);
	assign rd_key   = heap_rd_s1[EW-1:ID_W];
	assign rd_id    = heap_rd_s1[ID_W-1:0];
	assign ch_key   = child_q[EW-1:ID_W];
	assign cnt_m1   = count_q - CW'(1);

	always_comb begin
		state_d     = state_q;
		h_d         = h_q;
		k_d         = k_q;
		kid_d       = kid_q;
		first_d     = first_q;
		child_d     = child_q;
		n_d         = n_q;
		pend_d      = pend_q;
		tid_d       = tid_q;
		have_pend_d = have_pend_q;
		count_d     = count_q;
		present_d   = present_q;
		e_ev_d      = e_ev_q;
		e_exp_d     = e_exp_q;
		e_st_d      = e_st_q;
		e_last_d    = e_last_q;
		rd_en       = 1'b0;
		rd_addr     = '0;
		heap_we     = 1'b0;
		heap_waddr  = h_q;
		heap_wdata  = {k_q, kid_q};
		pmap_we     = 1'b0;
		pmap_waddr  = kid_q;
		pmap_wdata  = h_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_DISP;
			end
			S_DISP: begin
				e_ev_d = id_q; e_exp_d = 1'b0; e_st_d = ST_OK; e_last_d = 1'b1;
				case (cmd_q)
					CMD_SET: begin
						k_d = dl_q; kid_d = id_q; state_d = S_UP_RD;
						if (present_q[id_q]) begin
							h_d = pmap_rd_s1; first_d = 1'b1;
						end else if (count_q == CW'(CAPACITY)) begin
							e_st_d = ST_FULL; state_d = S_EMIT;
						end else begin
							h_d = count_q[HW-1:0]; first_d = 1'b0;
							count_d = count_q + CW'(1);
							present_d[id_q] = 1'b1;
						end
					end
					CMD_DEL: begin
						if (!present_q[id_q]) begin
							e_st_d = ST_ABSENT; state_d = S_EMIT;
						end else begin
							present_d[id_q] = 1'b0;
							count_d = cnt_m1;
							h_d = pmap_rd_s1;
							if (CW'(pmap_rd_s1) < cnt_m1) begin
								rd_en = 1'b1; rd_addr = cnt_m1[HW-1:0];
								state_d = S_LAST_EV;
							end else begin
								state_d = S_EMIT;
							end
						end
					end
					CMD_TICK: begin
						n_d = '0; have_pend_d = 1'b0; state_d = S_TICK_RD;
					end
					default: state_d = S_EMIT;
				endcase
			end
			S_LAST_EV: begin
				k_d = rd_key; kid_d = rd_id; first_d = 1'b1; state_d = S_UP_RD;
			end
			S_UP_RD: begin
				if (h_q == '0) begin
					if (first_q) begin
						state_d = S_DN_RD;
					end else begin
						heap_we = 1'b1; pmap_we = 1'b1;
						state_d = (cmd_q == CMD_TICK) ? S_TICK_RD : S_EMIT;
					end
				end else begin
					rd_en = 1'b1; rd_addr = par_idx; state_d = S_UP_EV;
				end
			end
			S_UP_EV: begin
				if (rd_key > k_q) begin
					heap_we = 1'b1; heap_wdata = heap_rd_s1;
					pmap_we = 1'b1; pmap_waddr = rd_id;
					h_d = par_idx; first_d = 1'b0; state_d = S_UP_RD;
				end else if (first_q) begin
					state_d = S_DN_RD;
				end else begin
					heap_we = 1'b1; pmap_we = 1'b1;
					state_d = (cmd_q == CMD_TICK) ? S_TICK_RD : S_EMIT;
				end
			end
			S_DN_RD: begin
				if (c1_w >= cnt_w) begin
					heap_we = 1'b1; pmap_we = 1'b1;
					state_d = (cmd_q == CMD_TICK) ? S_TICK_RD : S_EMIT;
				end else begin
					rd_en = 1'b1; rd_addr = c1_w[HW-1:0]; state_d = S_DN_E1;
				end
			end
			S_DN_E1, S_DN_E2: begin
				if (state_q == S_DN_E1 && c2_w < cnt_w) begin
					child_d = heap_rd_s1;
					rd_en = 1'b1; rd_addr = c2_w[HW-1:0]; state_d = S_DN_E2;
				end else begin
					// pick the smaller child, left wins ties
					logic [EW-1:0] ch;
					logic [HW-1:0] ci;
					if (state_q == S_DN_E2 && rd_key < ch_key) begin
						ch = heap_rd_s1; ci = c2_w[HW-1:0];
					end else if (state_q == S_DN_E2) begin
						ch = child_q; ci = c1_w[HW-1:0];
					end else begin
						ch = heap_rd_s1; ci = c1_w[HW-1:0];
					end
					if (ch[EW-1:ID_W] < k_q) begin
						heap_we = 1'b1; heap_wdata = ch;
						pmap_we = 1'b1; pmap_waddr = ch[ID_W-1:0];
						h_d = ci; state_d = S_DN_RD;
					end else begin
						heap_we = 1'b1; pmap_we = 1'b1;
						state_d = (cmd_q == CMD_TICK) ? S_TICK_RD : S_EMIT;
					end
				end
			end
			S_TICK_RD: begin
				if (count_q == '0 || n_q == NW'(MAX_RES)) begin
					e_exp_d = have_pend_q; e_ev_d = have_pend_q ? pend_q : '0;
					e_st_d = ST_OK; e_last_d = 1'b1; state_d = S_EMIT;
				end else begin
					rd_en = 1'b1; rd_addr = '0; state_d = S_TICK_EV;
				end
			end
			S_TICK_EV: begin
				tid_d = rd_id;
				if (rd_key <= now_q) begin
					if (have_pend_q) begin
						e_ev_d = pend_q; e_exp_d = 1'b1; e_st_d = ST_OK; e_last_d = 1'b0;
						state_d = S_EMIT;
					end else begin
						state_d = S_POP;
					end
				end else begin
					e_exp_d = have_pend_q; e_ev_d = have_pend_q ? pend_q : '0;
					e_st_d = ST_OK; e_last_d = 1'b1; state_d = S_EMIT;
				end
			end
			S_POP: begin
				pend_d = tid_q; have_pend_d = 1'b1; n_d = n_q + NW'(1);
				present_d[tid_q] = 1'b0;
				count_d = cnt_m1;
				h_d = '0;
				if (cnt_m1 > CW'(0)) begin
					rd_en = 1'b1; rd_addr = cnt_m1[HW-1:0]; state_d = S_LAST_EV;
				end else begin
					state_d = S_TICK_RD;
				end
			end
			S_EMIT: begin
				if (out_free) state_d = e_last_q ? S_IDLE : S_POP;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
		if (rd_en) heap_rd_s1 <= heap_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pmap_we) pmap_mem[pmap_waddr] <= pmap_wdata;
		if (accept) pmap_rd_s1 <= pmap_mem[req.event_id];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			present_q   <= '0;
			have_pend_q <= 1'b0;
			n_q         <= '0;
			first_q     <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			present_q   <= present_d;
			have_pend_q <= have_pend_d;
			n_q         <= n_d;
			first_q     <= first_d;
			if (state_q == S_EMIT && out_free) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			id_q  <= req.event_id;
			dl_q  <= sum_w[TIME_BITS-1:0];
			now_q <= now_w[TIME_BITS-1:0];
		end
		h_q      <= h_d;
		k_q      <= k_d;
		kid_q    <= kid_d;
		child_q  <= child_d;
		pend_q   <= pend_d;
		tid_q    <= tid_d;
		e_ev_q   <= e_ev_d;
		e_exp_q  <= e_exp_d;
		e_st_q   <= e_st_d;
		e_last_q <= e_last_d;
		if (state_q == S_EMIT && out_free) begin
			o_ev_q   <= e_ev_q;
			o_exp_q  <= e_exp_q;
			o_st_q   <= e_st_q;
			o_last_q <= e_last_q;
		end
	end

	assign rsp.valid     = ov_q;
	assign rsp.out_event = o_ev_q;
	assign rsp.expired   = o_exp_q;
	assign rsp.status    = o_st_q;
	assign rsp.last      = o_last_q;

	`IMH_ASSERT(a_count_bound, count_q <= CW'(CAPACITY))
	`IMH_ASSERT_NR(a_present_count, $countones(present_q) == int'(count_q))
	`IMH_ASSERT(a_mid_is_expired, (rsp.valid && !rsp.last) |-> rsp.expired)
	`IMH_ASSERT(a_accept_leaves_idle, accept |=> (state_q == S_DISP))
endmodule
`default_nettype wire
